// ----- design/positional_list_engine_assert.svh -----
// ---------------------------------------------------------------------------
// positional_list_engine_assert.svh
// Assertion macros for the positional list engine; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every rising clk edge outside reset.
`define PLE_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("positional_list_engine: assertion failed");
// Check that an expression is never true outside reset.
`define PLE_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("positional_list_engine: forbidden condition seen");
`else
`define PLE_ASSERT(label, prop)
`define PLE_ASSERT_NEVER(label, expr)
`endif

`endif

// ----- design/ple_pkg.sv -----
// ---------------------------------------------------------------------------
// ple_pkg
// Sizes, codes and shared types of the positional list engine.
// ---------------------------------------------------------------------------
package ple_pkg;

	localparam int CAPACITY = 16;
	localparam int VAL_W    = 32;
	localparam int POS_W    = 5;
	localparam int CMD_W    = 3;
	localparam int COUNT_W  = 5;
	localparam int LEN_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMP_W    = (LEN_W > POS_W) ? LEN_W : POS_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_HEAD = 3'd0,
		CMD_INS_TAIL = 3'd1,
		CMD_INS_POS  = 3'd2,
		CMD_DEL_HEAD = 3'd3,
		CMD_DEL_TAIL = 3'd4,
		CMD_DEL_POS  = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_INS  = 2'd1,
		OP_DEL  = 2'd2
	} op_t;

	// Controller to datapath.
	typedef struct packed {
		logic             load;
		op_t              op;
		logic [IDX_W-1:0] idx;
		status_t          status;
	} ctrl_t;

	// Datapath to controller.
	typedef struct packed {
		logic [LEN_W-1:0] len;
	} stat_t;

endpackage

// ----- design/ple_req_if.sv -----
// ---------------------------------------------------------------------------
// ple_req_if
// Command channel: valid/ready with cmd, position and value.
// ---------------------------------------------------------------------------
interface ple_req_if;
	logic                              valid;
	logic                              ready;
	logic [ple_pkg::CMD_W-1:0]         cmd;
	logic [ple_pkg::POS_W-1:0]         position;
	logic signed [ple_pkg::VAL_W-1:0]  value;

	modport source (output valid, output cmd, output position, output value, input ready);
	modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

// ----- design/ple_rsp_if.sv -----
// ---------------------------------------------------------------------------
// ple_rsp_if
// Result channel: valid/ready with status, removed_value and count.
// ---------------------------------------------------------------------------
interface ple_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        status;
	logic signed [ple_pkg::VAL_W-1:0]  removed_value;
	logic [ple_pkg::COUNT_W-1:0]       count;

	modport source (output valid, output status, output removed_value, output count,
		input ready);
	modport sink   (input valid, input status, input removed_value, input count,
		output ready);
endinterface

// ----- design/positional_list_engine.sv -----
// ---------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed values with positional insert and delete.
// ---------------------------------------------------------------------------
// Use:
//   req carries one command per item: cmd, 1-based position, value.
//   rsp returns one item per command: status, removed_value and count,
//   the list length after the command.
// Completion: the checks, shift and count of a command all complete in
//   the cycle it is accepted; its result is registered and held on rsp.
// Throughput: one item per cycle while rsp.ready is high. All slots
//   are flip-flops and shift in parallel, so the next command may
//   follow directly; the one-entry result register sets the limit.
// Stall: while a result waits and rsp.ready is low, req.ready stays low;
//   when rsp.ready is high a new command is taken in the same cycle the
//   held result leaves.
// Reset: arst_n clears the length and the result slot; slot contents are
//   not cleared and are never read before being written.
// ---------------------------------------------------------------------------
`include "positional_list_engine_assert.svh"

module positional_list_engine (
	input  logic      clk,
	input  logic      arst_n,
	ple_req_if.sink   req,
	ple_rsp_if.source rsp
);

	ple_pkg::ctrl_t ctrl;
	ple_pkg::stat_t stat;

	// Decode and flow control
	ple_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req.valid),
		.req_cmd      (req.cmd),
		.req_position (req.position),
		.req_ready    (req.ready),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.stat         (stat),
		.ctrl         (ctrl)
	);

	// Slots, length and result register
	ple_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.value         (req.value),
		.stat          (stat),
		.status        (rsp.status),
		.removed_value (rsp.removed_value),
		.count         (rsp.count)
	);

	// Every accepted command leaves a result in the output register.
	`PLE_ASSERT(a_accept_gives_result, ctrl.load |=> rsp.valid)
	// A successful insert grows the list by exactly one.
	`PLE_ASSERT(a_ins_grows, ctrl.load && ctrl.op == ple_pkg::OP_INS |=> stat.len == $past(stat.len) + 1'b1)
	// A successful delete shrinks the list by exactly one.
	`PLE_ASSERT(a_del_shrinks, ctrl.load && ctrl.op == ple_pkg::OP_DEL |=> stat.len == $past(stat.len) - 1'b1)
	// A flagged command never changes the list.
	`PLE_ASSERT(a_flag_no_change, ctrl.load && ctrl.status != ple_pkg::ST_DONE |=> $stable(stat.len))
	// The length never passes the capacity.
	`PLE_ASSERT_NEVER(a_len_bound, stat.len > ple_pkg::LEN_W'(ple_pkg::CAPACITY))

endmodule

// ----- design/ple_ctrl.sv -----
// ---------------------------------------------------------------------------
// ple_ctrl
// Command decode, status checks and result-slot state machine.
// ---------------------------------------------------------------------------
module ple_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  logic [ple_pkg::CMD_W-1:0] req_cmd,
	input  logic [ple_pkg::POS_W-1:0] req_position,
	output logic                      req_ready,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	input  ple_pkg::stat_t            stat,
	output ple_pkg::ctrl_t            ctrl
);

	typedef enum logic {
		S_FREE,
		S_HELD
	} state_t;

	state_t                      state_q;
	logic                        accept;
	logic                        full;
	logic                        empty;
	logic                        pos_ok;
	logic [ple_pkg::CMP_W-1:0]   pos_ext;
	logic [ple_pkg::CMP_W-1:0]   len_ext;
	logic [ple_pkg::POS_W-1:0]   pos_m1;
	logic [ple_pkg::LEN_W-1:0]   len_m1;

	assign rsp_valid = (state_q == S_HELD);
	assign req_ready = (state_q == S_FREE) || rsp_ready;
	assign accept    = req_valid && req_ready;

	assign full    = (stat.len == ple_pkg::LEN_W'(ple_pkg::CAPACITY));
	assign empty   = (stat.len == '0);
	assign pos_ext = ple_pkg::CMP_W'(req_position);
	assign len_ext = ple_pkg::CMP_W'(stat.len);
	assign pos_ok  = (pos_ext >= ple_pkg::CMP_W'(2)) && (pos_ext <= len_ext);
	assign pos_m1  = req_position - 1'b1;
	assign len_m1  = stat.len - 1'b1;

	always_comb begin
		ctrl.load   = accept;
		ctrl.op     = ple_pkg::OP_NONE;
		ctrl.idx    = '0;
		ctrl.status = ple_pkg::ST_DONE;
		unique case (ple_pkg::cmd_t'(req_cmd))
			ple_pkg::CMD_INS_HEAD: begin
				if (full) ctrl.status = ple_pkg::ST_FULL;
				else ctrl.op = ple_pkg::OP_INS;
			end
			ple_pkg::CMD_INS_TAIL: begin
				if (full) begin
					ctrl.status = ple_pkg::ST_FULL;
				end else begin
					ctrl.op  = ple_pkg::OP_INS;
					ctrl.idx = ple_pkg::IDX_W'(stat.len);
				end
			end
			ple_pkg::CMD_INS_POS: begin
				if (full) begin
					ctrl.status = ple_pkg::ST_FULL;
				end else if (!pos_ok) begin
					ctrl.status = ple_pkg::ST_BADPOS;
				end else begin
					ctrl.op  = ple_pkg::OP_INS;
					ctrl.idx = ple_pkg::IDX_W'(pos_m1);
				end
			end
			ple_pkg::CMD_DEL_HEAD: begin
				if (empty) ctrl.status = ple_pkg::ST_EMPTY;
				else ctrl.op = ple_pkg::OP_DEL;
			end
			ple_pkg::CMD_DEL_TAIL: begin
				if (empty) begin
					ctrl.status = ple_pkg::ST_EMPTY;
				end else begin
					ctrl.op  = ple_pkg::OP_DEL;
					ctrl.idx = ple_pkg::IDX_W'(len_m1);
				end
			end
			ple_pkg::CMD_DEL_POS: begin
				if (empty) begin
					ctrl.status = ple_pkg::ST_EMPTY;
				end else if (!pos_ok) begin
					ctrl.status = ple_pkg::ST_BADPOS;
				end else begin
					ctrl.op  = ple_pkg::OP_DEL;
					ctrl.idx = ple_pkg::IDX_W'(pos_m1);
				end
			end
			default: begin
				// unused codes: no change, status done
				ctrl.op = ple_pkg::OP_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FREE;
		end else if (accept) begin
			state_q <= S_HELD;
		end else if (rsp_ready) begin
			state_q <= S_FREE;
		end
	end

endmodule

// ----- design/ple_dp.sv -----
// ---------------------------------------------------------------------------
// ple_dp
// Slot registers with parallel shift, length counter and result register.
// ---------------------------------------------------------------------------
module ple_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ple_pkg::ctrl_t                   ctrl,
	input  logic signed [ple_pkg::VAL_W-1:0] value,
	output ple_pkg::stat_t                   stat,
	output logic [1:0]                       status,
	output logic signed [ple_pkg::VAL_W-1:0] removed_value,
	output logic [ple_pkg::COUNT_W-1:0]      count
);

	logic signed [ple_pkg::VAL_W-1:0] slots_q [ple_pkg::CAPACITY];
	logic [ple_pkg::LEN_W-1:0]        len_q;
	logic [ple_pkg::LEN_W-1:0]        len_next;
	logic [1:0]                       status_q;
	logic signed [ple_pkg::VAL_W-1:0] removed_q;
	logic [ple_pkg::COUNT_W-1:0]      count_q;

	assign stat.len      = len_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign count         = count_q;

	always_comb begin
		unique case (ctrl.op)
			ple_pkg::OP_INS: len_next = len_q + 1'b1;
			ple_pkg::OP_DEL: len_next = len_q - 1'b1;
			default:         len_next = len_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (ctrl.load) begin
			len_q <= len_next;
		end
	end

	// Shift every slot at once: open a gap on insert, close it on delete.
	always_ff @(posedge clk) begin
		if (ctrl.load && ctrl.op == ple_pkg::OP_INS) begin
			for (int k = 0; k < ple_pkg::CAPACITY; k++) begin
				if (ple_pkg::IDX_W'(k) == ctrl.idx) slots_q[k] <= value;
				else if (k > 0 && ple_pkg::IDX_W'(k) > ctrl.idx) slots_q[k] <= slots_q[k-1];
			end
		end else if (ctrl.load && ctrl.op == ple_pkg::OP_DEL) begin
			for (int k = 0; k < ple_pkg::CAPACITY - 1; k++) begin
				if (ple_pkg::IDX_W'(k) >= ctrl.idx) slots_q[k] <= slots_q[k+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			status_q  <= ctrl.status;
			removed_q <= (ctrl.op == ple_pkg::OP_DEL) ? slots_q[ctrl.idx] : '0;
			count_q   <= ple_pkg::COUNT_W'(len_next);
		end
	end

endmodule
